>>> rtl/sha_pkg.sv
package sha_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam logic [RoundW-1:0] RoundLast = RoundW'(NumRounds - 1);

  typedef logic [7:0][31:0]  hash_t;
  typedef logic [15:0][31:0] window_t;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        start_message;
    logic        final_block;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha_out_t;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [RoundW-1:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/sha256_block_compressor.sv
// SHA-256 compression engine. Words of a padded message come in one per beat,
// one per cycle while a block is being collected. On the 16th word of a block
// the input goes not-ready while 64 rounds run through a single round unit
// (one round per cycle, message schedule extended alongside in a 16-word
// shift window) and StAdd then folds the working variables into the hash.
// If any word of that block had final_block set, the eight digest words then
// leave as eight output beats, index 0 first, last flagged, and input stays
// blocked until the last one is taken. start_message reloads the initial hash
// values and drops any partly collected block; without it, blocks keep
// chaining.
module sha256_block_compressor import sha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sha_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sha_out_t out_data_o
);

  typedef enum logic [1:0] {StIdle, StRound, StAdd, StOut} state_e;

  state_e            state_q;
  hash_t             hash_q, vars_q, vars_next, hash_base;
  window_t           window_q;
  logic [31:0]       sched_new;
  logic [3:0]        cnt_q, cnt_eff;
  logic              pend_q, pend_eff;
  logic [RoundW-1:0] rnd_q;
  logic [2:0]        idx_q;
  logic              in_fire, out_fire, block_end;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign hash_base = in_data_i.start_message ? InitHash : hash_q;
  assign cnt_eff   = in_data_i.start_message ? 4'd0 : cnt_q;
  assign pend_eff  = (in_data_i.start_message ? 1'b0 : pend_q) | in_data_i.final_block;
  assign block_end = (cnt_eff == 4'd15);

  sha_round u_round (
    .vars_i  (vars_q),
    .window_i(window_q),
    .k_i     (round_k(rnd_q)),
    .vars_o  (vars_next),
    .sched_o (sched_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hash_q  <= InitHash;
      cnt_q   <= 4'd0;
      pend_q  <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= 3'd0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            hash_q <= hash_base;
            cnt_q  <= cnt_eff + 4'd1;
            pend_q <= pend_eff;
            if (block_end) begin
              rnd_q   <= '0;
              state_q <= StRound;
            end
          end
        end
        StRound: begin
          rnd_q <= rnd_q + RoundW'(1);
          if (rnd_q == RoundLast) begin
            state_q <= StAdd;
          end
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + vars_q[i];
          end
          if (pend_q) begin
            pend_q  <= 1'b0;
            idx_q   <= 3'd0;
            state_q <= StOut;
          end else begin
            state_q <= StIdle;
          end
        end
        StOut: begin
          if (out_fire) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      window_q <= {in_data_i.msg_word, window_q[15:1]};
      if (block_end) begin
        vars_q <= hash_base;
      end
    end else if (state_q == StRound) begin
      window_q <= {sched_new, window_q[15:1]};
      vars_q   <= vars_next;
    end
  end

  assign out_data_o.digest_word  = hash_q[idx_q];
  assign out_data_o.digest_index = idx_q;
  assign out_data_o.digest_last  = (idx_q == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest beats pending");

  a_rounds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == RoundLast) |=> (state_q == StAdd))
    else $error("round sequence did not end in hash update");

  a_count_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (cnt_q == 4'd0 && !in_ready_o))
    else $error("word count not wrapped during rounds");

  a_last_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.digest_last) |=> in_ready_o)
    else $error("input not released after last digest beat");

endmodule

>>> rtl/sha_round.sv
module sha_round import sha_pkg::*; (
  input  hash_t       vars_i,
  input  window_t     window_i,
  input  logic [31:0] k_i,
  output hash_t       vars_o,
  output logic [31:0] sched_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w, s0, s1, ch, maj, t1, t2, ls0, ls1;

  // window holds W[r..r+15], word 0 is this round's word
  assign w   = window_i[0];
  assign ls0 = rotr(window_i[1], 7) ^ rotr(window_i[1], 18) ^ (window_i[1] >> 3);
  assign ls1 = rotr(window_i[14], 17) ^ rotr(window_i[14], 19) ^ (window_i[14] >> 10);
  assign sched_o = window_i[0] + ls0 + window_i[9] + ls1;

  assign s1  = rotr(vars_i[4], 6) ^ rotr(vars_i[4], 11) ^ rotr(vars_i[4], 25);
  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign t1  = vars_i[7] + s1 + ch + k_i + w;
  assign s0  = rotr(vars_i[0], 2) ^ rotr(vars_i[0], 13) ^ rotr(vars_i[0], 22);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t2  = s0 + maj;

  assign vars_o[7] = vars_i[6];
  assign vars_o[6] = vars_i[5];
  assign vars_o[5] = vars_i[4];
  assign vars_o[4] = vars_i[3] + t1;
  assign vars_o[3] = vars_i[2];
  assign vars_o[2] = vars_i[1];
  assign vars_o[1] = vars_i[0];
  assign vars_o[0] = t1 + t2;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import sha_pkg::*;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sha_out_t out_data;

  // shadow copy of the engine state
  logic [31:0] chain_hash [8];
  logic [31:0] block_words [16];
  int unsigned words_in_block;
  logic        block_is_final;

  sha_out_t    pending_digest [$];
  int unsigned failures;
  int unsigned words_sent;
  bit          quiet;
  int unsigned stall_left;

  sha256_block_compressor i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] wr, t1, t2, w15, w2;
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = block_words[r];
      end else begin
        w15 = block_words[(r - 15) & 15];
        w2  = block_words[(r - 2) & 15];
        wr  = block_words[r & 15]
              + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
              + block_words[(r - 7) & 15]
              + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
        block_words[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
  endtask

  // update the shadow state with one accepted word, queue any digest it completes
  task automatic absorb_word(input sha_in_t w);
    sha_out_t d;
    if (w.start_message) begin
      for (int i = 0; i < 8; i++) chain_hash[i] = StartHash[i];
      words_in_block = 0;
      block_is_final = 1'b0;
    end
    if (w.final_block) block_is_final = 1'b1;
    block_words[words_in_block] = w.msg_word;
    if (words_in_block != 15) begin
      words_in_block++;
      return;
    end
    words_in_block = 0;
    compress_block();
    if (block_is_final) begin
      block_is_final = 1'b0;
      for (int k = 0; k < 8; k++) begin
        d.digest_word  = chain_hash[k];
        d.digest_index = 3'(k);
        d.digest_last  = (k == 7);
        pending_digest.push_back(d);
      end
    end
  endtask

  task automatic send_word(input logic [31:0] word, input logic start, input logic fin);
    sha_in_t w;
    w.msg_word      = word;
    w.start_message = start;
    w.final_block   = fin;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    absorb_word(w);
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // one message of whole blocks; the final flag lands somewhere in the last block
  task automatic send_message(input int unsigned blocks, input bit fresh);
    int unsigned mode, pos;
    logic        fin;
    mode = $urandom_range(0, 2);
    pos  = $urandom_range(0, 15);
    for (int b = 0; b < blocks; b++) begin
      for (int i = 0; i < 16; i++) begin
        fin = 1'b0;
        if (b == blocks - 1) begin
          case (mode)
            0:       fin = 1'b1;
            1:       fin = (i == pos);
            default: fin = (i >= pos);
          endcase
        end
        send_word(pick_word(), fresh && b == 0 && i == 0, fin);
      end
    end
  endtask

  task automatic test_abc_vector();
    // padded "abc", final flag only on the block's last word
    send_word(32'h61626380, 1'b1, 1'b0);
    for (int i = 1; i < 15; i++) send_word(32'h0, 1'b0, 1'b0);
    send_word(32'h00000018, 1'b0, 1'b1);
  endtask

  task automatic test_dropped_partial();
    // chains from the digest, then gets dropped by the next start
    send_word(32'hffffffff, 1'b0, 1'b0);
    send_word(32'h00000000, 1'b0, 1'b0);
    send_word(32'hffffffff, 1'b0, 1'b1);
    send_word(32'h80000000, 1'b0, 1'b0);
    send_word(32'h00000001, 1'b0, 1'b0);
  endtask

  task automatic test_random_messages(input int unsigned target);
    int unsigned n;
    n = 0;
    while (words_sent < target) begin
      send_message(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1,
                   n == 0 || $urandom_range(0, 4) != 0);
      // hold off until the engine has drained
      if (n == 0 || $urandom_range(0, 5) == 0) wait (pending_digest.size() == 0);
      n++;
    end
  endtask

  task automatic test_flag_noise(input int unsigned count);
    for (int i = 0; i < count; i++)
      send_word(pick_word(), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_back_to_back(input int unsigned target);
    quiet = 1'b1;
    while (words_sent < target) send_message(1, 1'b1);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
    end
  end

  always @(posedge clk) begin
    sha_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest.size() == 0) begin
        $display("%0t: digest beat with none expected, got %h", $time, out_data);
        failures++;
      end else begin
        want = pending_digest.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h got %h", $time,
                   want.digest_word, out_data.digest_word);
          failures++;
        end
        if (out_data.digest_index !== want.digest_index) begin
          $display("%0t: digest_index expected %0d got %0d", $time,
                   want.digest_index, out_data.digest_index);
          failures++;
        end
        if (out_data.digest_last !== want.digest_last) begin
          $display("%0t: digest_last expected %b got %b", $time,
                   want.digest_last, out_data.digest_last);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    failures       = 0;
    words_sent     = 0;
    quiet          = 1'b0;
    stall_left     = 0;
    words_in_block = 0;
    block_is_final = 1'b0;
    for (int i = 0; i < 8; i++) chain_hash[i] = StartHash[i];
    for (int i = 0; i < 16; i++) block_words[i] = 32'h0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_abc_vector();
    test_dropped_partial();
    test_random_messages(220);
    test_flag_noise(40);
    test_back_to_back(320);

    wait (pending_digest.size() == 0);
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
